### hw/rtl/rtt_pkg.sv
// Shared constants for the round-trip tracker.
`timescale 1ns / 1ps
package rtt_pkg;
    localparam int CLIENTS_DEF       = 16;
    localparam int HISTORY_DEPTH_DEF = 10;
    localparam int OPEN_DEPTH_DEF    = 8;
    localparam logic [7:0] RTT_CAP   = 8'd255;

    localparam logic [1:0] OP_PING = 2'd0;
    localparam logic [1:0] OP_PONG = 2'd1;
    localparam logic [1:0] OP_RTT  = 2'd2;
    localparam logic [1:0] OP_AGE  = 2'd3;   // ageing only, no operation
endpackage

### hw/rtl/rtt_tracker_weighted_average.sv
// Top level of the per-client round-trip tracker.
`timescale 1ns / 1ps
// Usage:
//   Command channel: drive i_op, i_client, i_seq, i_rtt_value, i_now_ms and
//   raise start while busy is low; that edge accepts the transaction.
//   One result transaction per command appears on the o_ ports for a single
//   cycle with o_valid high, in the cycle that busy falls; it cannot be stalled.
//   A sequencer walks per-client stores held in memories with registered reads:
//     - ageing: states S_AGE_R and S_AGE_D per check of the oldest open entry,
//     - open-queue removal: S_SH_R and S_SH_W per entry moved down, then S_SH_R,
//     - pong search: S_SRCH and S_SRCHD per entry examined,
//     - history push: an append, or, when full, a shift of every entry down first,
//     - weighted sum: one sample per cycle, then a division in rtt_div.
//   Each expired entry adds an open-queue removal and a history push; the
//   worst case is every open entry expiring into a full history. One
//   transaction at a time, no overlap.
//   Reset clears fill counts and the sequencer; store contents are never
//   read above the fill count and need no clearing.
module rtt_tracker_weighted_average #(
    parameter int CLIENTS       = rtt_pkg::CLIENTS_DEF,
    parameter int HISTORY_DEPTH = rtt_pkg::HISTORY_DEPTH_DEF,
    parameter int OPEN_DEPTH    = rtt_pkg::OPEN_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [3:0]  i_client,
    input  logic [7:0]  i_seq,
    input  logic [7:0]  i_rtt_value,
    input  logic [31:0] i_now_ms,
    output logic        o_valid,
    output logic [7:0]  o_avg_rtt,
    output logic [3:0]  o_history_count,
    output logic [3:0]  o_timeouts,
    output logic        o_matched,
    output logic        o_open_overflow
);
    localparam int CW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int OW = (OPEN_DEPTH > 1) ? $clog2(OPEN_DEPTH) : 1;
    localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int OFW = $clog2(OPEN_DEPTH + 1);
    localparam int HFW = $clog2(HISTORY_DEPTH + 1);
    localparam int OAW = (CLIENTS * OPEN_DEPTH > 1) ? $clog2(CLIENTS * OPEN_DEPTH) : 1;
    localparam int HAW = (CLIENTS * HISTORY_DEPTH > 1) ?
                         $clog2(CLIENTS * HISTORY_DEPTH) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_AGE_R = 4'd1;
    localparam logic [3:0] S_AGE_D = 4'd2;
    localparam logic [3:0] S_OP    = 4'd3;
    localparam logic [3:0] S_SRCH  = 4'd4;
    localparam logic [3:0] S_SRCHD = 4'd5;
    localparam logic [3:0] S_SH_R  = 4'd6;
    localparam logic [3:0] S_SH_W  = 4'd7;
    localparam logic [3:0] S_HP_R  = 4'd8;
    localparam logic [3:0] S_HP_W  = 4'd9;
    localparam logic [3:0] S_SUM_R = 4'd10;
    localparam logic [3:0] S_SUM_A = 4'd11;
    localparam logic [3:0] S_DIV   = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    // stores
    logic [7:0]  r_oseq [CLIENTS*OPEN_DEPTH];
    logic [31:0] r_otim [CLIENTS*OPEN_DEPTH];
    logic [7:0]  r_hist [CLIENTS*HISTORY_DEPTH];
    logic [OFW-1:0] r_ofill [CLIENTS];
    logic [HFW-1:0] r_hfill [CLIENTS];

    logic [3:0]  r_st;
    logic [3:0]  r_ret;         // state after a history push
    logic [3:0]  r_ret_sh;      // state after an open-queue removal
    logic [1:0]  r_op;
    logic [CW-1:0] r_c;
    logic [7:0]  r_seq, r_rv;
    logic [31:0] r_now;
    logic [OFW-1:0] r_of;
    logic [HFW-1:0] r_hf;
    logic [OW-1:0]  r_oi;       // open index
    logic [HW-1:0]  r_hi;       // history index
    logic [7:0]  r_push;
    logic [7:0]  r_rseq;
    logic [31:0] r_rtim;
    logic [7:0]  r_rh;
    logic [3:0]  r_to;
    logic        r_mat, r_ovf;
    logic [15:0] r_sum;
    logic [7:0]  r_wsum;
    logic [HFW-1:0] r_w;
    logic        r_dstart;
    logic        w_ddone;
    logic [7:0]  w_quot;
    logic [31:0] w_el;
    logic [OW-1:0] w_ai;
    logic [HW-1:0] w_hi;
    logic [OW-1:0] w_oaddr;
    logic [HW-1:0] w_haddr;
    logic [CW-1:0] w_cidx_tab [16];
    logic [CW-1:0] w_cidx;

    assign w_el = r_now - r_rtim;
    assign w_ai = r_oi + OW'(1);
    assign w_hi = r_hi + HW'(1);

    // client index reduced modulo CLIENTS: constant lookup
    for (genvar g = 0; g < 16; g++) begin : g_cidx
        assign w_cidx_tab[g] = CW'(g % CLIENTS);
    end
    assign w_cidx = w_cidx_tab[i_client];

    // read one entry ahead while shifting and summing
    assign w_oaddr = (r_st == S_SH_R) ? w_ai : r_oi;
    assign w_haddr = (r_st == S_HP_R || r_st == S_SUM_A) ? w_hi :
                     (r_st == S_SUM_R) ? HW'(0) : r_hi;

    rtt_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num(r_sum), .i_den(r_wsum), .o_done(w_ddone), .o_quot(w_quot)
    );

    function automatic logic [OAW-1:0] oa(input logic [CW-1:0] c, input logic [OW-1:0] i);
        oa = OAW'(int'(c) * OPEN_DEPTH + int'(i));
    endfunction
    function automatic logic [HAW-1:0] ha(input logic [CW-1:0] c, input logic [HW-1:0] i);
        ha = HAW'(int'(c) * HISTORY_DEPTH + int'(i));
    endfunction

    assign busy = (r_st != S_IDLE);

    always_ff @(posedge i_clk) begin
        r_rseq <= r_oseq[oa(r_c, w_oaddr)];
        r_rtim <= r_otim[oa(r_c, w_oaddr)];
        r_rh   <= r_hist[ha(r_c, w_haddr)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            o_valid  <= 1'b0;
            r_dstart <= 1'b0;
            for (int k = 0; k < CLIENTS; k++) begin
                r_ofill[k] <= '0;
                r_hfill[k] <= '0;
            end
        end else begin
            o_valid  <= 1'b0;
            r_dstart <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    if (start) begin
                        r_op  <= i_op;
                        r_c   <= w_cidx;
                        r_seq <= i_seq;
                        r_rv  <= i_rtt_value;
                        r_now <= i_now_ms;
                        r_of  <= r_ofill[w_cidx];
                        r_hf  <= r_hfill[w_cidx];
                        r_oi  <= '0;
                        r_to  <= '0;
                        r_mat <= 1'b0;
                        r_ovf <= 1'b0;
                        r_st  <= S_AGE_R;
                    end
                end
                S_AGE_R: r_st <= S_AGE_D;   // read slot 0
                S_AGE_D: begin
                    if (r_of != '0 && w_el >= 32'd255) begin
                        if (r_to != 4'd15) r_to <= r_to + 4'd1;
                        r_push   <= rtt_pkg::RTT_CAP;
                        r_oi     <= '0;
                        r_ret_sh <= S_HP_R;
                        r_ret    <= S_AGE_R;
                        r_st     <= S_SH_R;
                    end else begin
                        r_st <= S_OP;
                    end
                end
                S_OP: begin
                    r_oi <= '0;
                    r_hi <= '0;
                    case (r_op)
                        rtt_pkg::OP_PING: begin
                            if (r_of == OFW'(OPEN_DEPTH)) begin
                                r_ovf <= 1'b1;
                                r_ret_sh <= S_OP;
                                r_st <= S_SH_R;
                            end else begin
                                r_oseq[oa(r_c, OW'(r_of))] <= r_seq;
                                r_otim[oa(r_c, OW'(r_of))] <= r_now;
                                r_of <= r_of + OFW'(1);
                                r_op <= rtt_pkg::OP_AGE;   // done; fall through to average
                                r_st <= S_OP;
                            end
                        end
                        rtt_pkg::OP_PONG: r_st <= (r_of == '0) ? S_SUM_R : S_SRCH;
                        rtt_pkg::OP_RTT: begin
                            r_push <= r_rv;
                            r_ret  <= S_SUM_R;
                            r_st   <= S_HP_R;
                        end
                        default: begin
                            r_sum <= '0;
                            r_wsum <= '0;
                            r_w   <= r_hf;
                            r_st  <= S_SUM_R;
                        end
                    endcase
                end
                S_SRCH: r_st <= S_SRCHD;
                S_SRCHD: begin
                    if (r_rseq == r_seq) begin
                        r_mat    <= 1'b1;
                        r_push   <= (w_el > 32'd255) ? rtt_pkg::RTT_CAP : w_el[7:0];
                        r_ret_sh <= S_HP_R;
                        r_ret    <= S_SUM_R;
                        r_st     <= S_SH_R;
                    end else if (OFW'(r_oi) + OFW'(1) >= r_of) begin
                        r_st <= S_SUM_R;
                    end else begin
                        r_oi <= w_ai;
                        r_st <= S_SRCH;
                    end
                end
                // remove open entry r_oi, shifting newer entries down
                S_SH_R: begin
                    if (OFW'(r_oi) + OFW'(1) >= r_of) begin
                        r_of <= r_of - OFW'(1);
                        r_hi <= '0;
                        r_st <= r_ret_sh;
                    end else begin
                        r_st <= S_SH_W;
                    end
                end
                S_SH_W: begin
                    r_oseq[oa(r_c, r_oi)] <= r_rseq;
                    r_otim[oa(r_c, r_oi)] <= r_rtim;
                    r_oi <= w_ai;
                    r_st <= S_SH_R;
                end
                // history push: shift when full, then append
                S_HP_R: begin
                    if (r_hf != HFW'(HISTORY_DEPTH)) begin
                        r_hist[ha(r_c, HW'(r_hf))] <= r_push;
                        r_hf <= r_hf + HFW'(1);
                        r_oi <= '0;
                        r_st <= r_ret;
                    end else if (HFW'(r_hi) + HFW'(1) >= r_hf) begin
                        r_hf <= r_hf - HFW'(1);
                    end else begin
                        r_st <= S_HP_W;
                    end
                end
                S_HP_W: begin
                    r_hist[ha(r_c, r_hi)] <= r_rh;
                    r_hi <= w_hi;
                    r_st <= S_HP_R;
                end
                S_SUM_R: begin
                    r_sum  <= '0;
                    r_wsum <= '0;
                    r_hi   <= '0;
                    r_w    <= r_hf;
                    r_ofill[r_c] <= r_of;
                    r_hfill[r_c] <= r_hf;
                    r_st <= (r_hf == '0) ? S_OUT : S_SUM_A;
                end
                S_SUM_A: begin
                    if (r_w == '0) begin
                        r_dstart <= 1'b1;
                        r_st <= S_DIV;
                    end else begin
                        r_sum  <= r_sum + 16'(r_rh) * 16'(r_w);
                        r_wsum <= r_wsum + 8'(r_w);
                        r_w    <= r_w - HFW'(1);
                        r_hi   <= w_hi;
                    end
                end
                S_DIV: if (w_ddone) r_st <= S_OUT;
                S_OUT: begin
                    o_valid         <= 1'b1;
                    o_avg_rtt       <= (r_hf == '0) ? rtt_pkg::RTT_CAP : w_quot;
                    o_history_count <= (32'(r_hf) > 32'd15) ? 4'd15 : 4'(r_hf);
                    o_timeouts      <= r_to;
                    o_matched       <= r_mat;
                    o_open_overflow <= r_ovf;
                    r_st            <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result while busy");
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accept did not go busy");
    a_hcnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_history_count <= 4'(HISTORY_DEPTH))) else $error("count");
    a_mo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_matched && o_open_overflow)) else $error("flags");
`endif
endmodule

### hw/rtl/rtt_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module rtt_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_num,
    input  logic [7:0]  i_den,
    output logic        o_done,
    output logic [7:0]  o_quot
);
    logic [15:0] r_q;
    logic [8:0]  r_rem;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [8:0]  n_try;
    logic        n_ge;

    always_comb begin
        n_try = {r_rem[7:0], r_q[15]};
        n_ge  = (n_try >= {1'b0, i_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd16;
                r_q    <= i_num;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= n_ge ? n_try - {1'b0, i_den} : n_try;
                r_q   <= {r_q[14:0], n_ge};
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quot = r_q[7:0];
endmodule
